/* rtl/nps_pkg.sv */
package nps_pkg;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arr;
		logic [11:0] burst;
		logic [7:0]  prio;
	} job_t;

	// One ring slot: a job plus its occupancy and completion marks.
	typedef struct packed {
		logic valid;
		logic done;
		job_t job;
	} slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_EMIT
	} state_t;

endpackage

/* rtl/nps_slot.sv */
module nps_slot
	import nps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  clr,
	input  logic  shift,
	input  slot_t nxt,
	output slot_t cur
);

	logic valid_q;
	logic done_q;
	job_t job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt.valid;
			done_q  <= nxt.done;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			job_q <= nxt.job;
		end
	end

	assign cur = '{valid: valid_q, done: done_q, job: job_q};

endmodule

/* rtl/nps_select.sv */
module nps_select
	import nps_pkg::*;
#(
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             en,
	input  logic             first,
	input  logic [16:0]      tick,
	input  slot_t            head,
	input  logic             head_done,
	input  logic [IDX_W-1:0] step,
	output logic             found_rdy,
	output job_t             pick,
	output logic [IDX_W-1:0] pick_step
);

	logic             rdy_found_q;
	job_t             rdy_job_q;
	logic [IDX_W-1:0] rdy_step_q;
	logic             ea_found_q;
	job_t             ea_job_q;
	logic [IDX_W-1:0] ea_step_q;

	logic eligible;
	logic arrived;
	logic rdy_better;
	logic ea_better;

	assign eligible = head.valid && !head.done && !head_done;
	assign arrived  = !first && ({1'b0, head.job.arr} <= tick);

	// Strict comparisons keep the earlier slot on a full tie, which is load order.
	always_comb begin
		rdy_better = (head.job.prio > rdy_job_q.prio) ||
			((head.job.prio == rdy_job_q.prio) && (head.job.arr < rdy_job_q.arr)) ||
			((head.job.prio == rdy_job_q.prio) && (head.job.arr == rdy_job_q.arr) &&
			 (head.job.id < rdy_job_q.id));
		ea_better = (head.job.arr < ea_job_q.arr) ||
			((head.job.arr == ea_job_q.arr) && (head.job.prio > ea_job_q.prio)) ||
			((head.job.arr == ea_job_q.arr) && (head.job.prio == ea_job_q.prio) &&
			 (head.job.id < ea_job_q.id));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_found_q <= 1'b0;
			ea_found_q  <= 1'b0;
		end else if (clr) begin
			rdy_found_q <= 1'b0;
			ea_found_q  <= 1'b0;
		end else if (en && eligible) begin
			if (arrived) begin
				rdy_found_q <= 1'b1;
			end
			ea_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && eligible) begin
			if (arrived && (!rdy_found_q || rdy_better)) begin
				rdy_job_q  <= head.job;
				rdy_step_q <= step;
			end
			if (!ea_found_q || ea_better) begin
				ea_job_q  <= head.job;
				ea_step_q <= step;
			end
		end
	end

	// With nothing arrived, the job with the earliest pending arrival is picked and starts at its arrival.
	assign found_rdy = rdy_found_q;
	assign pick      = rdy_found_q ? rdy_job_q : ea_job_q;
	assign pick_step = rdy_found_q ? rdy_step_q : ea_step_q;

endmodule

/* rtl/nonpreemptive_priority_scheduler.sv */
// Loading accepts one item per cycle; in_ready stays high between job sets.
// After the item marked last, each result takes one full turn of the job ring past the
// selection head (ST_SCAN), then the ST_CALC and ST_EMIT arithmetic states.
// A finished result waits in the output register while the ring scans for the next one.
// Asynchronous reset empties the ring and clears counters, timer and sums.
module nonpreemptive_priority_scheduler
	import nps_pkg::*;
#(
	parameter int MAX_PROCESSES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] process_id,
	input  logic [15:0] arrival_time,
	input  logic [11:0] burst_time,
	input  logic [7:0]  priority_level,
	input  logic        last_process,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] process_id_res,
	output logic [16:0] start_time,
	output logic [16:0] completion_time,
	output logic [16:0] turnaround_time,
	output logic [16:0] waiting_time,
	output logic [20:0] total_turnaround,
	output logic [20:0] total_waiting,
	output logic [16:0] schedule_length,
	output logic        last_result
);

	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
	localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_PROCESSES - 1);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_PROCESSES);

	state_t state_q, state_d;

	slot_t slot_w [MAX_PROCESSES];
	slot_t tail_in;
	logic  ring_shift;
	logic  ring_clr;

	logic [CNT_W-1:0] job_cnt_q;
	logic [CNT_W-1:0] done_cnt_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] mark_step_q;
	logic             mark_valid_q;
	logic             mark_hit;
	logic             first_q;
	logic [16:0]      tick_q;
	logic [15:0]      first_arr_q;
	logic [20:0]      tsum_q;
	logic [20:0]      wsum_q;
	logic [17:0]      max_ct_q;

	logic             found_rdy;
	job_t             pick;
	logic [IDX_W-1:0] pick_step;

	job_t        pick_q;
	logic [16:0] start_q;
	logic [17:0] ct_q;
	logic [20:0] wt_q;

	logic        in_fire;
	logic        room;
	logic        load;
	logic        out_free;
	logic        is_last;
	logic [16:0] start_c;
	logic [20:0] tat_c;
	logic [20:0] tsum_c;
	logic [20:0] wsum_c;
	logic [17:0] max_c;
	logic [17:0] len_c;

	logic        out_valid_q;
	logic [15:0] id_out_q;
	logic [16:0] start_out_q;
	logic [16:0] ct_out_q;
	logic [16:0] tat_out_q;
	logic [16:0] wt_out_q;
	logic [20:0] tsum_out_q;
	logic [20:0] wsum_out_q;
	logic [16:0] len_out_q;
	logic        last_out_q;

	assign in_fire  = in_valid && in_ready;
	assign room     = job_cnt_q < CNT_MAX;
	assign load     = in_fire && room;
	assign out_free = !out_valid_q || out_ready;
	assign mark_hit = mark_valid_q && (step_q == mark_step_q);
	assign is_last  = CNT_W'(done_cnt_q + 1'b1) == job_cnt_q;

	// Job ring: each slot takes its neighbor's; the head wraps to the tail in ST_SCAN.
	assign ring_shift = load || (state_q == ST_SCAN);
	assign ring_clr   = (state_q == ST_EMIT) && out_free && is_last;

	always_comb begin
		if (state_q == ST_SCAN) begin
			tail_in      = slot_w[0];
			tail_in.done = slot_w[0].done || mark_hit;
		end else begin
			tail_in = '{valid: 1'b1, done: 1'b0,
				job: '{id: process_id, arr: arrival_time, burst: burst_time,
					prio: priority_level}};
		end
	end

	for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_ring
		slot_t nxt;
		if (i == MAX_PROCESSES - 1) begin : g_tail
			assign nxt = tail_in;
		end else begin : g_body
			assign nxt = slot_w[i+1];
		end
		nps_slot u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (ring_clr),
			.shift  (ring_shift),
			.nxt    (nxt),
			.cur    (slot_w[i])
		);
	end

	nps_select #(
		.IDX_W (IDX_W)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (state_q != ST_SCAN),
		.en        (state_q == ST_SCAN),
		.first     (first_q),
		.tick      (tick_q),
		.head      (slot_w[0]),
		.head_done (mark_hit),
		.step      (step_q),
		.found_rdy (found_rdy),
		.pick      (pick),
		.pick_step (pick_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && last_process) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = is_last ? ST_IDLE : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Waiting time equals start minus arrival, so it needs no second subtract.
	assign start_c = found_rdy ? tick_q : {1'b0, pick.arr};
	assign tat_c   = {3'b0, ct_q} - {5'b0, pick_q.arr};
	assign tsum_c  = tsum_q + tat_c;
	assign wsum_c  = wsum_q + wt_q;
	assign max_c   = (ct_q > max_ct_q) ? ct_q : max_ct_q;
	assign len_c   = max_c - {2'b0, first_arr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_cnt_q    <= '0;
			done_cnt_q   <= '0;
			step_q       <= '0;
			mark_step_q  <= '0;
			mark_valid_q <= 1'b0;
			first_q      <= 1'b0;
			tick_q       <= '0;
			first_arr_q  <= '0;
			tsum_q       <= '0;
			wsum_q       <= '0;
			max_ct_q     <= '0;
		end else begin
			if (load) begin
				job_cnt_q <= CNT_W'(job_cnt_q + 1'b1);
			end
			if (in_fire && last_process) begin
				first_q <= 1'b1;
			end
			case (state_q)
				ST_SCAN: begin
					step_q <= (step_q == LAST_STEP) ? '0 : IDX_W'(step_q + 1'b1);
				end
				ST_CALC: begin
					tick_q       <= 17'(({1'b0, start_c} + {6'b0, pick.burst}));
					mark_step_q  <= pick_step;
					mark_valid_q <= 1'b1;
					first_q      <= 1'b0;
					if (first_q) begin
						first_arr_q <= pick.arr;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (is_last) begin
							job_cnt_q    <= '0;
							done_cnt_q   <= '0;
							mark_valid_q <= 1'b0;
							tick_q       <= '0;
							tsum_q       <= '0;
							wsum_q       <= '0;
							max_ct_q     <= '0;
						end else begin
							done_cnt_q <= CNT_W'(done_cnt_q + 1'b1);
							tsum_q     <= tsum_c;
							wsum_q     <= wsum_c;
							max_ct_q   <= max_c;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			pick_q  <= pick;
			start_q <= start_c;
			ct_q    <= {1'b0, start_c} + {6'b0, pick.burst};
			wt_q    <= {4'b0, start_c} - {5'b0, pick.arr};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			id_out_q    <= pick_q.id;
			start_out_q <= start_q;
			ct_out_q    <= ct_q[16:0];
			tat_out_q   <= tat_c[16:0];
			wt_out_q    <= wt_q[16:0];
			tsum_out_q  <= is_last ? tsum_c : '0;
			wsum_out_q  <= is_last ? wsum_c : '0;
			len_out_q   <= is_last ? len_c[16:0] : '0;
			last_out_q  <= is_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign process_id_res   = id_out_q;
	assign start_time       = start_out_q;
	assign completion_time  = ct_out_q;
	assign turnaround_time  = tat_out_q;
	assign waiting_time     = wt_out_q;
	assign total_turnaround = tsum_out_q;
	assign total_waiting    = wsum_out_q;
	assign schedule_length  = len_out_q;
	assign last_result      = last_out_q;

endmodule

/* rtl/nps_checker.sv */
module nps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last_process,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] process_id_res,
	input logic [16:0] start_time,
	input logic [16:0] completion_time,
	input logic [16:0] turnaround_time,
	input logic [16:0] waiting_time,
	input logic [20:0] total_turnaround,
	input logic [20:0] total_waiting,
	input logic [16:0] schedule_length,
	input logic        last_result
);

	// A stalled result keeps its id, its times and its last-result flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(process_id_res) &&
			$stable(start_time) && $stable(completion_time) &&
			$stable(turnaround_time) && $stable(waiting_time) && $stable(last_result))
		else $error("result changed while stalled");

	// The item that closes a set starts the schedule, so no item is taken next.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_process |=> !in_ready)
		else $error("item accepted while a schedule is running");

	// An intermediate result on the output means the set is still being scheduled.
	a_busy_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> !in_ready)
		else $error("input opened before the last result");

	// Totals show only on the last result of a set.
	a_totals_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> (total_turnaround == 21'd0) &&
			(total_waiting == 21'd0) && (schedule_length == 17'd0))
		else $error("totals on an intermediate result");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (.*);
